// ----- src/qgd_pkg.sv -----
// Shared types and constants for the quantized gradient direction block.
// Depends on nothing; every other file of the block but qgd_ram imports it.
package qgd_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WEFF_W     = $clog2(MAX_WIDTH + 1);
  localparam int HEFF_W     = $clog2(MAX_HEIGHT + 1);
  localparam int COORD_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int MIN_SIZE   = 3;

  localparam int WIDTH_RESET  = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int HEIGHT_RESET = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2,
    REG_SPARE     = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_HORZ  = 3'd1,
    DIR_DIAG  = 3'd2,
    DIR_VERT  = 3'd3,
    DIR_ANTI  = 3'd4
  } dir_t;

  typedef struct packed {
    logic [PIX_W-1:0]  threshold;
    logic [WEFF_W-1:0] width;
    logic [HEFF_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic               emit;
    logic [COL_W-1:0]   addr;
    logic [COORD_W-1:0] row_m1;
    logic [COORD_W-1:0] col_m1;
  } pos_t;

  // Six window registers: top, middle, bottom of column c-2, then of c-1.
  typedef logic [5:0][PIX_W-1:0] win_t;

endpackage

// ----- src/qgd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module qgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/qgd_cfg.sv -----
// Configuration registers: threshold and the frame size, held already clamped.
// Depends on qgd_pkg.
module qgd_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [qgd_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [qgd_pkg::CFG_DATA_W-1:0] wr_data,
  output qgd_pkg::cfg_t                  cfg
);
  import qgd_pkg::*;

  logic [WEFF_W-1:0] width_clamped;
  logic [HEFF_W-1:0] height_clamped;

  always_comb begin
    if (32'(wr_data) < MIN_SIZE) begin
      width_clamped  = WEFF_W'(MIN_SIZE);
    end else if (32'(wr_data) > MAX_WIDTH) begin
      width_clamped  = WEFF_W'(MAX_WIDTH);
    end else begin
      width_clamped  = WEFF_W'(wr_data);
    end
    if (32'(wr_data) < MIN_SIZE) begin
      height_clamped = HEFF_W'(MIN_SIZE);
    end else if (32'(wr_data) > MAX_HEIGHT) begin
      height_clamped = HEFF_W'(MAX_HEIGHT);
    end else begin
      height_clamped = HEFF_W'(wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold <= '0;
      cfg.width     <= WEFF_W'(WIDTH_RESET);
      cfg.height    <= HEFF_W'(HEIGHT_RESET);
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_THRESHOLD: cfg.threshold <= wr_data[PIX_W-1:0];
        REG_WIDTH:     cfg.width     <= width_clamped;
        REG_HEIGHT:    cfg.height    <= height_clamped;
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- src/qgd_scan.sv -----
// Raster position counters: gives the position of the arriving word and
// whether its window centre is interior. Depends on qgd_pkg.
module qgd_scan (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic          frame_start,
  input  qgd_pkg::cfg_t cfg,
  output qgd_pkg::pos_t pos
);
  import qgd_pkg::*;

  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_next;
  logic [ROW_W-1:0] row_next;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic [COL_W:0]   col_inc;
  logic [ROW_W:0]   row_inc;

  always_comb begin
    col_cur = frame_start ? '0 : col_count;
    row_cur = frame_start ? '0 : row_count;

    pos.addr   = col_cur;
    pos.emit   = (32'(row_cur) >= 2) && (32'(row_cur) < 32'(cfg.height)) &&
                 (32'(col_cur) >= 2) && (32'(col_cur) < 32'(cfg.width));
    pos.row_m1 = COORD_W'(row_cur) - COORD_W'(1);
    pos.col_m1 = COORD_W'(col_cur) - COORD_W'(1);

    col_inc  = {1'b0, col_cur} + (COL_W+1)'(1);
    row_inc  = {1'b0, row_cur} + (ROW_W+1)'(1);
    col_next = col_inc[COL_W-1:0];
    row_next = row_cur;
    if (32'(col_inc) >= 32'(cfg.width)) begin
      col_next = '0;
      row_next = row_inc[ROW_W-1:0];
      if (32'(row_inc) >= 32'(cfg.height)) begin
        row_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_next;
      row_count <= row_next;
    end
  end

endmodule

// ----- src/qgd_pick.sv -----
// Absolute differences of the four opposite neighbour pairs and the choice
// of the strongest one above the threshold. Depends on qgd_pkg.
module qgd_pick (
  input  qgd_pkg::win_t                 win,
  input  logic [qgd_pkg::PIX_W-1:0]     top,
  input  logic [qgd_pkg::PIX_W-1:0]     mid,
  input  logic [qgd_pkg::PIX_W-1:0]     bot,
  input  logic [qgd_pkg::PIX_W-1:0]     threshold,
  output qgd_pkg::dir_t                 dir,
  output logic [qgd_pkg::PIX_W-1:0]     strength
);
  import qgd_pkg::*;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  logic [PIX_W-1:0] d_horz;
  logic [PIX_W-1:0] d_diag;
  logic [PIX_W-1:0] d_vert;
  logic [PIX_W-1:0] d_anti;
  logic [PIX_W-1:0] best;

  always_comb begin
    d_horz = abs_diff(mid, win[1]);
    d_diag = abs_diff(bot, win[0]);
    d_vert = abs_diff(win[5], win[3]);
    d_anti = abs_diff(win[2], top);

    best = threshold;
    dir  = DIR_NONE;
    if (d_horz > best) begin
      best = d_horz;
      dir  = DIR_HORZ;
    end
    if (d_diag > best) begin
      best = d_diag;
      dir  = DIR_DIAG;
    end
    if (d_vert > best) begin
      best = d_vert;
      dir  = DIR_VERT;
    end
    if (d_anti > best) begin
      best = d_anti;
      dir  = DIR_ANTI;
    end
    strength = (dir == DIR_NONE) ? '0 : best;
  end

endmodule

// ----- src/quantized_gradient_direction.sv -----
// Top level of the quantized gradient direction block: stage register, line
// store, window registers and result register. Depends on qgd_pkg, qgd_ram,
// qgd_cfg, qgd_scan and qgd_pick.
//
// Usage: pixels arrive in raster order on the input channel (in_valid,
// in_ready), frame_start marking the first word of a frame. For every interior
// centre pixel one word leaves on the output channel (out_valid, out_ready)
// with the direction code, its strength and the centre's row and column;
// border positions give no word. The configuration channel (cfg_valid,
// cfg_ready, always ready) writes threshold, width and height by index and is
// to be used only while the block is idle.
// An accepted word enters the stage register; its result goes on to the result
// register. Throughput is one word per cycle unless the receiver stalls; the
// line store is read at the accept edge and written as the word leaves the
// stage register (single write port), with a bypass when both touch one column.
// Reset clears the position counters, window registers and configuration
// (threshold 0, 640 by 480); line store contents stay unknown until written.
// When the receiver stalls the result register holds, one more word is taken
// into the stage register and in_ready then falls until the result leaves.
module quantized_gradient_direction (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [qgd_pkg::PIX_W-1:0]      pixel,
  input  logic                           frame_start,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     direction,
  output logic [qgd_pkg::PIX_W-1:0]      strength,
  output logic [qgd_pkg::COORD_W-1:0]    out_row,
  output logic [qgd_pkg::COORD_W-1:0]    out_col,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [qgd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qgd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import qgd_pkg::*;

  cfg_t cfg;
  pos_t pos;
  logic in_accept;

  logic             s1_valid;
  logic             s1_adv;
  pos_t             s1_pos;
  logic [PIX_W-1:0] s1_pixel;
  logic             fwd_hit;
  logic [PIX_W-1:0] fwd_top;
  logic [PIX_W-1:0] fwd_mid;

  logic [2*PIX_W-1:0] ram_rdata;
  logic [2*PIX_W-1:0] ram_wdata;
  logic [PIX_W-1:0]   top;
  logic [PIX_W-1:0]   mid;
  win_t               win;

  dir_t             pick_dir;
  logic [PIX_W-1:0] pick_strength;

  assign cfg_ready = 1'b1;
  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_adv;
  assign in_accept = in_valid && in_ready;

  qgd_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  qgd_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .frame_start (frame_start),
    .cfg         (cfg),
    .pos         (pos)
  );

  // Upper byte holds the row before last, lower byte the previous row.
  assign ram_wdata = {mid, s1_pixel};

  qgd_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_pos.addr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (pos.addr),
    .rdata (ram_rdata)
  );

  assign top = fwd_hit ? fwd_top : ram_rdata[2*PIX_W-1:PIX_W];
  assign mid = fwd_hit ? fwd_mid : ram_rdata[PIX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
      fwd_hit  <= s1_adv && (s1_pos.addr == pos.addr);
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pos   <= pos;
      s1_pixel <= pixel;
      fwd_top  <= mid;
      fwd_mid  <= s1_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_adv) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= s1_pixel;
    end
  end

  qgd_pick u_pick (
    .win       (win),
    .top       (top),
    .mid       (mid),
    .bot       (s1_pixel),
    .threshold (cfg.threshold),
    .dir       (pick_dir),
    .strength  (pick_strength)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_pos.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_pos.emit) begin
      direction <= pick_dir;
      strength  <= pick_strength;
      out_row   <= s1_pos.row_m1;
      out_col   <= s1_pos.col_m1;
    end
  end

`ifndef NO_ASSERTIONS
  a_stage_not_overrun: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |-> !in_ready)
    else $error("stage register would be overwritten while held");

  a_no_direction_no_strength: assert property (@(posedge clk) disable iff (rst)
    (out_valid && direction == DIR_NONE) |-> (strength == '0))
    else $error("strength set without a direction");

  a_direction_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (direction <= DIR_ANTI))
    else $error("direction code out of range");

  a_row_interior: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_row != '0))
    else $error("result for a border row");

  a_result_from_stage: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result appeared without a staged word");
`endif

endmodule

// ----- tb/quantized_gradient_direction_tb.sv -----
// Self-checking testbench for quantized_gradient_direction: streams frames of
// several sizes and thresholds through the block and checks every result word.
// Depends on qgd_pkg and the block's RTL; needs nothing else to run.
module quantized_gradient_direction_tb;
  import qgd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned RANDOM_WORDS = 700;

  typedef struct {
    dir_t               dir;
    logic [PIX_W-1:0]   strength;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
  } gradient_t;

  class gradient_tracker;
    bit [PIX_W-1:0]      threshold = '0;
    bit [CFG_DATA_W-1:0] width_reg = CFG_DATA_W'(WIDTH_RESET);
    bit [CFG_DATA_W-1:0] height_reg = CFG_DATA_W'(HEIGHT_RESET);
    bit [PIX_W-1:0]      prev_row [MAX_WIDTH];
    bit [PIX_W-1:0]      older_row [MAX_WIDTH];
    bit [PIX_W-1:0]      win [6];
    int unsigned         col = 0;
    int unsigned         row = 0;
    gradient_t           due [$];
    int unsigned         errors = 0;
    int unsigned         words_in = 0;
    int unsigned         checked = 0;
    int unsigned         writes = 0;

    function int unsigned size_of(bit [CFG_DATA_W-1:0] v, int unsigned hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned gap_of(bit [PIX_W-1:0] a, bit [PIX_W-1:0] b);
      return (a > b) ? a - b : b - a;
    endfunction

    function int unsigned eff_width();
      return size_of(width_reg, MAX_WIDTH);
    endfunction

    function int unsigned waiting();
      return due.size();
    endfunction

    function void apply_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_THRESHOLD: threshold = data[PIX_W-1:0];
        REG_WIDTH: width_reg = data;
        REG_HEIGHT: height_reg = data;
        default: ;
      endcase
      writes++;
    endfunction

    function void take_pixel(logic [PIX_W-1:0] bot, logic fs);
      int unsigned w, h, best;
      int unsigned d [4];
      bit [PIX_W-1:0] top, mid;
      dir_t cand;
      gradient_t g;
      w = size_of(width_reg, MAX_WIDTH);
      h = size_of(height_reg, MAX_HEIGHT);
      if (fs) begin
        col = 0;
        row = 0;
      end
      top = older_row[col];
      mid = prev_row[col];
      if (row >= 2 && row < h && col >= 2 && col < w) begin
        d[0] = gap_of(mid, win[1]);
        d[1] = gap_of(bot, win[0]);
        d[2] = gap_of(win[5], win[3]);
        d[3] = gap_of(win[2], top);
        best = threshold;
        g.dir = DIR_NONE;
        cand = DIR_HORZ;
        for (int i = 0; i < 4; i++) begin
          if (d[i] > best) begin
            best = d[i];
            g.dir = cand;
          end
          cand = cand.next();
        end
        g.strength = (g.dir == DIR_NONE) ? '0 : best[PIX_W-1:0];
        g.row = COORD_W'(row - 1);
        g.col = COORD_W'(col - 1);
        due.push_back(g);
      end
      older_row[col] = mid;
      prev_row[col] = bot;
      win[0] = win[3];
      win[1] = win[4];
      win[2] = win[5];
      win[3] = top;
      win[4] = mid;
      win[5] = bot;
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
      words_in++;
    endfunction

    task report(string what);
      if (errors < 40) $display("MISMATCH: %s", what);
      errors++;
    endtask

    task check_gradient(logic [2:0] dir, logic [PIX_W-1:0] str,
                        logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
      gradient_t g;
      checked++;
      if (due.size() == 0) begin
        report($sformatf("unexpected word: dir %0d strength %0d at row %0d col %0d",
                         dir, str, r, c));
        return;
      end
      g = due.pop_front();
      if (dir !== g.dir || str !== g.strength || r !== g.row || c !== g.col)
        report($sformatf("got dir %0d str %0d (%0d,%0d), wanted dir %0d str %0d (%0d,%0d)",
                         dir, str, r, c, g.dir, g.strength, g.row, g.col));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      pixel = '0;
  logic                  frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [2:0]            direction;
  logic [PIX_W-1:0]      strength;
  logic [COORD_W-1:0]    out_row;
  logic [COORD_W-1:0]    out_col;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  gradient_tracker sb = new();
  int unsigned     cycles = 0;
  int unsigned     stall_left = 0;
  int unsigned     send_idle_pct = 0;
  int unsigned     recv_idle_pct = 0;
  int unsigned     sent = 0;
  int unsigned     phases = 0;
  bit              calm = 1'b0;

  localparam logic [PIX_W-1:0] DIRECTED_ROWS [24] = '{
    8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd255,
    8'd0,   8'd0,   8'd0,
    8'd255, 8'd200, 8'd0,
    8'd255, 8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,
    8'd101, 8'd0,   8'd255
  };

  quantized_gradient_direction u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .pixel(pixel), .frame_start(frame_start),
    .out_valid(out_valid), .out_ready(out_ready), .direction(direction),
    .strength(strength), .out_row(out_row), .out_col(out_col),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped by the cycle limit with %0d results due.", sb.waiting());
      $display("quantized_gradient_direction_tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.apply_reg(reg_idx_t'(cfg_index), cfg_data);
      if (in_valid && in_ready) sb.take_pixel(pixel, frame_start);
      if (out_valid && out_ready) sb.check_gradient(direction, strength, out_row, out_col);
    end
  end

  // The receiver stalls in bursts, and only while calm is clear.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else if (!calm && recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
      out_ready = 1'b0;
      stall_left = $urandom_range(12);
    end else begin
      out_ready = 1'b1;
    end
  end

  task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic fs);
    int unsigned gap = 0;
    if (!calm && send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
      gap = $urandom_range(1, 13);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    pixel = pix;
    frame_start = fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Holds the sender back until every due result has arrived, then lets the
  // stage register empty out as well.
  task automatic settle();
    in_valid = 1'b0;
    while (sb.waiting() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input logic [PIX_W-1:0] thr, input logic [CFG_DATA_W-1:0] w,
                           input logic [CFG_DATA_W-1:0] h, input int unsigned n,
                           input bit keep);
    int unsigned old_w;
    logic [PIX_W-1:0] pix;
    bit smooth;
    bit fs;
    settle();
    old_w = sb.eff_width();
    set_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    set_reg(REG_WIDTH, w);
    set_reg(REG_HEIGHT, h);
    // A wider row would read line store entries never written, so restart.
    if (sb.eff_width() > old_w) keep = 1'b0;
    smooth = 1'($urandom_range(1));
    pix = PIX_W'($urandom);
    for (int i = 0; i < n; i++) begin
      fs = (i == 0 && !keep) || ($urandom_range(149) == 0);
      if (smooth) pix = pix + PIX_W'($urandom_range(16)) - 8'd8;
      else pix = PIX_W'($urandom);
      push_pixel(pix, fs);
    end
    sent += n;
    phases++;
  endtask

  initial begin
    logic [PIX_W-1:0] thr;
    logic [CFG_DATA_W-1:0] w, h;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    set_reg(REG_SPARE, CFG_DATA_W'($urandom));
    set_reg(REG_THRESHOLD, CFG_DATA_W'(100));
    set_reg(REG_WIDTH, CFG_DATA_W'(3));
    set_reg(REG_HEIGHT, CFG_DATA_W'(10));
    for (int i = 0; i < 24; i++) push_pixel(DIRECTED_ROWS[i], i == 0);
    phases++;

    send_idle_pct = 10;
    recv_idle_pct = 10;
    run_phase(8'd0, 13'd5, 13'd4, 60, 1'b0);
    run_phase(8'd255, 13'd7, 13'd6, 60, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(8'd20, 13'd0, 13'd1, 40, 1'b0);
    run_phase(8'd40, 13'd2, 13'd2, 30, 1'b0);
    send_idle_pct = 25;
    recv_idle_pct = 25;
    run_phase(8'd30, 13'd16, 13'd12, 155, 1'b0);
    run_phase(8'd30, 13'd9, 13'd12, 100, 1'b1);
    run_phase(8'd30, 13'd9, 13'd4, 60, 1'b1);

    while (sent < RANDOM_WORDS) begin
      case ($urandom_range(3))
        0: thr = '0;
        1: thr = PIX_W'($urandom_range(60));
        2: thr = PIX_W'($urandom);
        default: thr = '1;
      endcase
      case ($urandom_range(9))
        0: w = CFG_DATA_W'($urandom_range(2));
        1: w = CFG_DATA_W'($urandom_range(25, 70));
        default: w = CFG_DATA_W'($urandom_range(3, 24));
      endcase
      h = ($urandom_range(9) == 0) ? CFG_DATA_W'($urandom_range(2))
                                   : CFG_DATA_W'($urandom_range(3, 12));
      send_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 30);
      recv_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 30);
      run_phase(thr, w, h, $urandom_range(30, 120), 1'($urandom_range(1)));
    end

    // Sizes above the range, clamped to the widest row and the tallest
    // frame, run last at full rate.
    calm = 1'b1;
    run_phase(PIX_W'($urandom), 13'd4097, 13'd3, 40, 1'b0);
    run_phase(PIX_W'($urandom), 13'd3, 13'd8191, 45, 1'b0);

    settle();
    repeat (8) @(negedge clk);
    $display("Streamed %0d pixel words over %0d frame settings with %0d register writes.",
             sb.words_in, phases, sb.writes);
    $display("Checked %0d result words, over clamped small frames and out-of-range sizes.",
             sb.checked);
    if (sb.errors == 0) begin
      $display("quantized_gradient_direction_tb passed");
    end else begin
      $display("quantized_gradient_direction_tb failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/qgd_pkg.sv
src/qgd_ram.sv
src/qgd_cfg.sv
src/qgd_scan.sv
src/qgd_pick.sv
src/quantized_gradient_direction.sv
tb/quantized_gradient_direction_tb.sv
